// ----- rtl/core/leb_pkg.sv -----
package leb_pkg;

  localparam int unsigned LEB_DEPTH    = 256;
  localparam int unsigned LEB_IDX_W    = $clog2(LEB_DEPTH);
  localparam int unsigned LEB_GRP_SIZE = 16;
  localparam int unsigned LEB_GROUPS   = LEB_DEPTH / LEB_GRP_SIZE;
  localparam int unsigned LEB_CAP_W    = 9;
  localparam logic [LEB_CAP_W-1:0] LEB_CAP_MIN = LEB_CAP_W'(2);
  localparam logic [LEB_CAP_W-1:0] LEB_CAP_MAX =
    LEB_CAP_W'((LEB_DEPTH < 256) ? LEB_DEPTH : 256);
  localparam logic [LEB_CAP_W-1:0] LEB_CAP_RESET = LEB_CAP_W'(256);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SETCUR = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOCHAR = 2'd2,
    ST_PAST   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_in;
    logic [7:0] position;
  } leb_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_char;
    logic [7:0] text_length;
    logic [7:0] cursor_now;
  } leb_out_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic [LEB_IDX_W-1:0] cursor;
    logic [7:0]           ch;
    logic [LEB_IDX_W-1:0] pos;
  } leb_cmd_t;

endpackage

// ----- rtl/core/line_edit_buffer_with_cursor.sv -----
// Insert, delete, set-cursor and clear return their result in the cycle after
// acceptance; read passes S_RD0 and S_RD1 through a two-level OR tree first.
// One transaction is in flight at a time: 1 transaction per cycle for edits
// while the output is not stalled; a read holds off new input until it ends.
// Reset clears length, cursor, capacity (to 256) and the output valid; the
// character cells are not reset.
module line_edit_buffer_with_cursor
  import leb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  leb_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output leb_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [LEB_CAP_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD0  = 2'd1;
  localparam logic [1:0] S_RD1  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [LEB_IDX_W-1:0] len_q, len_d;
  logic [LEB_IDX_W-1:0] cur_q, cur_d;
  logic [LEB_IDX_W-1:0] pos_q, pos_d;
  logic [LEB_CAP_W-1:0] cap_q;
  logic                 out_valid_q, out_valid_d;
  leb_out_t             out_q, out_d;

  logic [LEB_CAP_W-1:0] cap_eff;
  logic [LEB_CAP_W-1:0] cap_m1;
  logic                 full;
  logic                 acc;
  logic                 load;
  logic [7:0]           grp [LEB_GROUPS];
  logic [7:0]           grp_or;
  leb_cmd_t             cmd;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    cap_eff = cap_q;
    if (cap_eff < LEB_CAP_MIN) cap_eff = LEB_CAP_MIN;
    if (cap_eff > LEB_CAP_MAX) cap_eff = LEB_CAP_MAX;
    cap_m1 = cap_eff - LEB_CAP_W'(1);
    full   = {1'b0, len_q} >= cap_m1;
  end

  always_comb begin
    grp_or = 8'd0;
    for (int g = 0; g < LEB_GROUPS; g++) begin
      grp_or = grp_or | grp[g];
    end
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    load       = 1'b0;
    out_d      = out_q;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.cursor = cur_q;
    cmd.ch     = in_data_i.char_in;
    cmd.pos    = pos_q;
    out_d.status    = ST_OK;
    out_d.read_char = 8'd0;
    if (state_q == S_IDLE) begin
      if (acc) begin
        load = 1'b1;
        unique case (in_data_i.op)
          OP_INSERT: begin
            if (full) begin
              out_d.status = ST_FULL;
            end else begin
              cmd.ins = 1'b1;
              len_d   = len_q + LEB_IDX_W'(1);
              cur_d   = cur_q + LEB_IDX_W'(1);
            end
          end
          OP_DELETE: begin
            if (cur_q >= len_q) begin
              out_d.status = ST_NOCHAR;
            end else begin
              cmd.del = 1'b1;
              len_d   = len_q - LEB_IDX_W'(1);
            end
          end
          OP_SETCUR: begin
            if (in_data_i.position > len_q) begin
              out_d.status = ST_PAST;
            end else begin
              cur_d = in_data_i.position;
            end
          end
          OP_CLEAR: begin
            len_d = '0;
            cur_d = '0;
          end
          OP_READ: begin
            if (in_data_i.position > len_q) begin
              out_d.status = ST_PAST;
            end else begin
              // hand the offset to the read tree and wait for it
              load    = 1'b0;
              pos_d   = in_data_i.position;
              state_d = S_RD0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state_q == S_RD0) begin
      state_d = S_RD1;
    end else begin
      load            = 1'b1;
      out_d.read_char = (pos_q < len_q) ? grp_or : 8'd0;
      state_d         = S_IDLE;
    end
    out_d.text_length = len_d;
    out_d.cursor_now  = cur_d;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  leb_row u_row (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .grp_o (grp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      cap_q       <= LEB_CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cur_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond text length");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while a read is in flight");

  a_rd_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |=> (state_q == S_RD1))
    else $error("read sequence broken");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.op == OP_INSERT && !full) |=>
      (len_q == $past(len_q) + LEB_IDX_W'(1)))
    else $error("insert did not grow the text");

  a_rd_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |=> out_valid_q)
    else $error("read finished without a result");

endmodule

// ----- rtl/core/leb_cell.sv -----
module leb_cell
  import leb_pkg::*;
(
  input  logic                 clk_i,
  input  logic [LEB_IDX_W-1:0] idx_i,
  input  leb_cmd_t             cmd_i,
  input  logic [7:0]           left_i,
  input  logic [7:0]           right_i,
  output logic [7:0]           data_o,
  output logic [7:0]           rd_o
);

  logic [7:0] char_q;
  logic [7:0] char_d;

  always_comb begin
    char_d = char_q;
    if (cmd_i.ins) begin
      // shift the tail right, drop the new character at the cursor
      if (idx_i > cmd_i.cursor) begin
        char_d = left_i;
      end else if (idx_i == cmd_i.cursor) begin
        char_d = cmd_i.ch;
      end
    end else if (cmd_i.del) begin
      if (idx_i >= cmd_i.cursor) begin
        char_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign data_o = char_q;
  assign rd_o   = (idx_i == cmd_i.pos) ? char_q : 8'd0;

endmodule

// ----- rtl/core/leb_row.sv -----
module leb_row
  import leb_pkg::*;
(
  input  logic       clk_i,
  input  leb_cmd_t   cmd_i,
  output logic [7:0] grp_o [LEB_GROUPS]
);

  logic [7:0] data [LEB_DEPTH];
  logic [7:0] rd   [LEB_DEPTH];
  logic [7:0] grp_d [LEB_GROUPS];
  logic [7:0] grp_q [LEB_GROUPS];

  for (genvar i = 0; i < LEB_DEPTH; i++) begin : g_cell
    logic [7:0] left_w;
    logic [7:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = 8'd0;
    end else begin : g_mid_l
      assign left_w = data[i-1];
    end
    if (i == LEB_DEPTH - 1) begin : g_last
      assign right_w = 8'd0;
    end else begin : g_mid_r
      assign right_w = data[i+1];
    end
    leb_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (LEB_IDX_W'(i)),
      .cmd_i   (cmd_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data[i]),
      .rd_o    (rd[i])
    );
  end

  // first level of the read tree: OR each group of masked cell outputs
  always_comb begin
    for (int g = 0; g < LEB_GROUPS; g++) begin
      grp_d[g] = 8'd0;
      for (int k = 0; k < LEB_GRP_SIZE; k++) begin
        grp_d[g] = grp_d[g] | rd[g*LEB_GRP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

// ----- tb/line_edit_buffer_with_cursor_tb.sv -----
module line_edit_buffer_with_cursor_tb
  import leb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Tracks the line, the cursor and the capacity, and keeps the replies that
  // the accepted edits must produce, oldest first.
  class edit_scoreboard;
    logic [7:0]  line_chars [LEB_DEPTH];
    int unsigned len;
    int unsigned cur;
    logic [LEB_CAP_W-1:0] capacity;
    leb_out_t    line_replies_q[$];
    int unsigned errors;

    function new();
      len      = 0;
      cur      = 0;
      capacity = LEB_CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [LEB_CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return line_replies_q.size();
    endfunction

    function int unsigned usable_capacity();
      int unsigned c;
      c = capacity;
      if (c < LEB_CAP_MIN) c = LEB_CAP_MIN;
      if (c > LEB_CAP_MAX) c = LEB_CAP_MAX;
      return c;
    endfunction

    function void apply_edit(leb_in_t edit);
      leb_out_t    reply;
      int unsigned i;
      reply        = '0;
      reply.status = ST_OK;
      case (edit.op)
        OP_INSERT: begin
          if (len >= usable_capacity() - 1 || cur > len || len >= LEB_DEPTH) begin
            reply.status = ST_FULL;
          end else begin
            // shift the tail right, then drop the character in at the cursor
            for (i = len; i > cur; i--) line_chars[i] = line_chars[i-1];
            line_chars[cur] = edit.char_in;
            len++;
            cur++;
          end
        end
        OP_DELETE: begin
          if (cur >= len) begin
            reply.status = ST_NOCHAR;
          end else begin
            for (i = cur; i + 1 < len; i++) line_chars[i] = line_chars[i+1];
            len--;
          end
        end
        OP_SETCUR: begin
          if (edit.position > len) reply.status = ST_PAST;
          else cur = edit.position;
        end
        OP_CLEAR: begin
          len = 0;
          cur = 0;
        end
        OP_READ: begin
          if (edit.position > len) reply.status = ST_PAST;
          else if (edit.position < len) reply.read_char = line_chars[edit.position];
        end
        default: begin
        end
      endcase
      reply.text_length = 8'(len);
      reply.cursor_now  = 8'(cur);
      line_replies_q.push_back(reply);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(leb_out_t got);
      leb_out_t want;
      if (line_replies_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = line_replies_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("read_char", want.read_char, got.read_char);
      compare_field("text_length", want.text_length, got.text_length);
      compare_field("cursor_now", want.cursor_now, got.cursor_now);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  leb_in_t              in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [LEB_CAP_W-1:0] cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  leb_out_t             out_data;

  bit             calm_tail = 1'b0;
  int unsigned    stall_left;
  int unsigned    flow_left;
  edit_scoreboard sb;

  line_edit_buffer_with_cursor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver back-pressure: bursts of stall separated by free-running stretches.
  always @(posedge clk) begin
    if (calm_tail) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left != 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = $urandom_range(0, 15);
      flow_left  = $urandom_range(0, 40);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.apply_edit(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic send_edit(input leb_in_t edit);
    int unsigned gap;
    gap = (!calm_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= edit;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] ch, input logic [7:0] pos);
    leb_in_t edit;
    edit.op       = op;
    edit.char_in  = ch;
    edit.position = pos;
    send_edit(edit);
  endtask

  // Drain every outstanding transaction before touching the capacity.
  task automatic write_capacity(input logic [LEB_CAP_W-1:0] value);
    in_valid <= 1'b0;
    // let the monitor log the last accepted transaction first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  function automatic leb_in_t next_edit(int unsigned ins_pct, int unsigned clr_pct);
    leb_in_t     edit;
    int unsigned roll;
    edit.char_in  = 8'($urandom_range(0, 255));
    edit.position = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, sb.len));
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) edit.op = OP_INSERT;
    else if (roll < ins_pct + 12) edit.op = OP_DELETE;
    else if (roll < ins_pct + 30) edit.op = OP_SETCUR;
    else if (roll < ins_pct + 30 + clr_pct) edit.op = OP_CLEAR;
    else if (roll == 99) edit.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else edit.op = OP_READ;
    return edit;
  endfunction

  task automatic run_phase(int unsigned count, int unsigned ins_pct, int unsigned clr_pct);
    repeat (count) send_edit(next_edit(ins_pct, clr_pct));
  endtask

  initial begin
    logic [LEB_CAP_W-1:0] caps [$];
    int unsigned          extra;
    int unsigned          guard;

    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty line, end and past-length cases, middle edits, spare codes.
    send_op(OP_READ, 8'h00, 8'd0);
    send_op(OP_READ, 8'h00, 8'd255);
    send_op(OP_DELETE, 8'h00, 8'd0);
    send_op(OP_SETCUR, 8'h00, 8'd1);
    send_op(OP_SETCUR, 8'h00, 8'd0);
    send_op(OP_INSERT, 8'h00, 8'd0);
    send_op(OP_INSERT, 8'hFF, 8'd255);
    send_op(OP_INSERT, 8'hA5, 8'd0);
    send_op(OP_SETCUR, 8'h00, 8'd1);
    send_op(OP_INSERT, 8'h5A, 8'd0);
    send_op(OP_READ, 8'h00, 8'd0);
    send_op(OP_READ, 8'h00, 8'd1);
    send_op(OP_READ, 8'h00, 8'd3);
    send_op(OP_READ, 8'h00, 8'd4);
    send_op(OP_READ, 8'h00, 8'd5);
    send_op(OP_DELETE, 8'h00, 8'd0);
    send_op(OP_SETCUR, 8'h00, 8'd3);
    send_op(OP_DELETE, 8'h00, 8'd0);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_op(3'(op), 8'hFF, 8'hFF);
    send_op(OP_SETCUR, 8'h00, 8'd0);
    send_op(OP_DELETE, 8'h00, 8'd0);
    send_op(OP_CLEAR, 8'h00, 8'd0);
    send_op(OP_READ, 8'h00, 8'd0);

    // Fill the line to the top of the full capacity, then keep pushing.
    extra = 0;
    guard = 0;
    while ((sb.len < LEB_CAP_MAX - 1 || extra < 12) && guard < 600) begin
      if (sb.len >= LEB_CAP_MAX - 1) extra++;
      send_edit(next_edit(80, 0));
      guard++;
    end

    // Shrink the capacity under the text that is already held.
    write_capacity(LEB_CAP_W'(4));
    run_phase(60, 40, 2);

    caps.push_back(LEB_CAP_W'(2));
    caps.push_back(LEB_CAP_W'(0));
    caps.push_back(LEB_CAP_W'(1));
    caps.push_back(LEB_CAP_W'(3));
    caps.push_back(LEB_CAP_W'(511));
    caps.push_back(LEB_CAP_W'($urandom_range(5, 255)));
    caps.push_back(LEB_CAP_W'(300));
    foreach (caps[k]) begin
      write_capacity(caps[k]);
      run_phase(70, 45, 3);
    end

    write_capacity(LEB_CAP_RESET);
    calm_tail = 1'b1;
    run_phase(70, 50, 3);

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
